// File: rtl/lfm_pkg.sv
// ----------------------------------------------------------------------------
// lfm_pkg
// Shared types and constants of the lamp fault monitor: request kinds,
// detector classes, event codes, register indexes and the queue entry.
// ----------------------------------------------------------------------------
package lfm_pkg;

   localparam int CHANNEL_W   = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_DETECT_ENABLE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLTAGE_CHECK_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_CHECK_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLTAGE_FLASH_ENABLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_FLASH_ENABLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAULT_THRESHOLD      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP_SCANS        = 3'd6;

   localparam logic [3:0] RESET_THRESHOLD = 4'd12;
   localparam logic [5:0] RESET_STARTUP   = 6'd48;
   localparam logic [5:0] STARTUP_MAX     = 6'h3f;
   localparam logic [3:0] COUNT_MAX       = 4'hf;

   // fault bit positions
   localparam int FAULT_GREEN  = 0;
   localparam int FAULT_RG     = 1;
   localparam int FAULT_REDOFF = 2;

   // detector positions in the event mask, in emission order
   localparam int DET_RG     = 0;
   localparam int DET_GREEN  = 1;
   localparam int DET_REDOFF = 2;
   localparam int NUM_DET    = 3;

   typedef enum logic {
      KIND_SAMPLE  = 1'b0,
      KIND_RESTORE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CLS_NONE   = 2'd0,
      CLS_ERROR  = 2'd1,
      CLS_NORMAL = 2'd2
   } cls_type;

   typedef enum logic [2:0] {
      EVT_RG_SET       = 3'd0,
      EVT_RG_CLEAR     = 3'd1,
      EVT_GREEN_SET    = 3'd2,
      EVT_GREEN_CLEAR  = 3'd3,
      EVT_REDOFF_SET   = 3'd4,
      EVT_REDOFF_CLEAR = 3'd5
   } event_code_type;

   typedef struct packed {
      logic       detect_enable;
      logic       voltage_check_enable;
      logic       current_check_enable;
      logic       voltage_flash_enable;
      logic       current_flash_enable;
      logic [3:0] fault_threshold;
      logic [5:0] startup_scans;
   } cfg_type;

   typedef struct packed {
      kind_type             kind;
      logic                 chan_ok;
      logic [CHANNEL_W-1:0] channel;
      logic                 last_in_scan;
      cls_type              rg_cls;
      cls_type              green_cls;
      cls_type              redoff_cls;
      logic [2:0]           restore_bits;
   } item_type;

endpackage

// File: rtl/lamp_fault_monitor_unit.sv
// ----------------------------------------------------------------------------
// lamp_fault_monitor_unit
// Traffic-signal lamp fault monitor: per-channel conflict and red-off
// detection with streak counters, fault latching and set/clear events.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  one channel sample or one restore of saved fault bits per request.
//   rsp_*  zero to three events per request, in order red-green, green,
//          red off; rsp_last_event marks the final event of a request.
//   csr_*  register writes, always ready; write only when idle (unchecked).
// Timing:
//   A request enters a two-entry queue on acceptance; the back end takes it
//   once the event register has room, updates the channel counters in one
//   read-modify-write and shows its first event in the cycle after that.
//   Requests without events flow at one per cycle while none are pending;
//   others hold the back end until the single event register drains.
// Reset:
//   Counters, fault bits, startup count and the fault latch clear; registers
//   return to their defaults (threshold 12, startup scans 48).
// Stall:
//   While rsp_ready is low the event is held, the queue fills and req_ready
//   drops once both queue entries are taken.
// ----------------------------------------------------------------------------
module lamp_fault_monitor_unit #(
   parameter int CHANNELS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [lfm_pkg::CHANNEL_W-1:0]   req_channel,
   input  logic                            req_last_in_scan,
   input  logic [2:0]                      req_commanded,
   input  logic [1:0]                      req_voltage_readback,
   input  logic [7:0]                      req_red_current,
   input  logic [7:0]                      req_red_current_base,
   input  logic [7:0]                      req_red_current_margin,
   input  logic [2:0]                      req_restore_bits,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_event_code,
   output logic [lfm_pkg::CHANNEL_W-1:0]   rsp_event_channel,
   output logic                            rsp_flash_request,
   output logic                            rsp_last_event,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lfm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lfm_pkg::CSR_DATA_W-1:0]  csr_data
);

   lfm_pkg::cfg_type  cfg_ff;
   lfm_pkg::cfg_type  cfg_in;
   lfm_pkg::item_type push_item;
   lfm_pkg::item_type pop_item;
   logic              push_valid;
   logic              push_ready;
   logic              pop_valid;
   logic              pop_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lfm_pkg::CSR_DETECT_ENABLE:        cfg_in.detect_enable        = csr_data[0];
            lfm_pkg::CSR_VOLTAGE_CHECK_ENABLE: cfg_in.voltage_check_enable = csr_data[0];
            lfm_pkg::CSR_CURRENT_CHECK_ENABLE: cfg_in.current_check_enable = csr_data[0];
            lfm_pkg::CSR_VOLTAGE_FLASH_ENABLE: cfg_in.voltage_flash_enable = csr_data[0];
            lfm_pkg::CSR_CURRENT_FLASH_ENABLE: cfg_in.current_flash_enable = csr_data[0];
            lfm_pkg::CSR_FAULT_THRESHOLD:      cfg_in.fault_threshold      = csr_data[3:0];
            lfm_pkg::CSR_STARTUP_SCANS:        cfg_in.startup_scans        = csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                 <= '0;
         cfg_ff.fault_threshold <= lfm_pkg::RESET_THRESHOLD;
         cfg_ff.startup_scans   <= lfm_pkg::RESET_STARTUP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lfm_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_channel           (req_channel),
      .req_last_in_scan      (req_last_in_scan),
      .req_commanded         (req_commanded),
      .req_voltage_readback  (req_voltage_readback),
      .req_red_current       (req_red_current),
      .req_red_current_base  (req_red_current_base),
      .req_red_current_margin(req_red_current_margin),
      .req_restore_bits      (req_restore_bits),
      .push_valid            (push_valid),
      .push_ready            (push_ready),
      .push_item             (push_item)
   );

   lfm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item (push_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item)
   );

   lfm_back #(
      .CHANNELS(CHANNELS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_code   (rsp_event_code),
      .rsp_event_channel(rsp_event_channel),
      .rsp_flash_request(rsp_flash_request),
      .rsp_last_event   (rsp_last_event)
   );

`ifndef ASSERT_OFF
   a_restore_silent: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && pop_item.kind == lfm_pkg::KIND_RESTORE) |=> !rsp_valid)
      else $error("restore request produced an event");

   a_bad_channel_silent: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && !pop_item.chan_ok) |=> !rsp_valid)
      else $error("out-of-range channel produced an event");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_event && !(pop_valid && pop_ready)) |=> !rsp_valid)
      else $error("event still pending after last event taken");

   a_flash_on_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flash_request) |->
         (rsp_event_code == lfm_pkg::EVT_RG_SET || rsp_event_code == lfm_pkg::EVT_GREEN_SET ||
          rsp_event_code == lfm_pkg::EVT_REDOFF_SET))
      else $error("flash request on a clear event");
`endif

endmodule

// File: rtl/lfm_front.sv
// ----------------------------------------------------------------------------
// lfm_front
// Request front end: takes a request and classifies it for the three
// detectors, then hands the classified entry to the queue.
// ----------------------------------------------------------------------------
module lfm_front #(
   parameter int CHANNELS = 32
) (
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [lfm_pkg::CHANNEL_W-1:0] req_channel,
   input  logic                         req_last_in_scan,
   input  logic [2:0]                   req_commanded,
   input  logic [1:0]                   req_voltage_readback,
   input  logic [7:0]                   req_red_current,
   input  logic [7:0]                   req_red_current_base,
   input  logic [7:0]                   req_red_current_margin,
   input  logic [2:0]                   req_restore_bits,
   output logic                         push_valid,
   input  logic                         push_ready,
   output lfm_pkg::item_type            push_item
);

   localparam logic [lfm_pkg::CHANNEL_W:0] CHAN_LIMIT = (lfm_pkg::CHANNEL_W + 1)'(CHANNELS);

   logic       cmd_red;
   logic       cmd_green;
   logic       volt_red;
   logic       volt_green;
   logic [8:0] cur_plus_margin;

   assign cmd_red    = req_commanded[1];
   assign cmd_green  = req_commanded[0];
   assign volt_red   = req_voltage_readback[1];
   assign volt_green = req_voltage_readback[0];

   // current below base - margin is current + margin below base
   assign cur_plus_margin = {1'b0, req_red_current} + {1'b0, req_red_current_margin};

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

   always_comb begin
      push_item              = '0;
      push_item.kind         = lfm_pkg::kind_type'(req_kind);
      push_item.chan_ok      = {1'b0, req_channel} < CHAN_LIMIT;
      push_item.channel      = req_channel;
      push_item.last_in_scan = req_last_in_scan;
      push_item.restore_bits = req_restore_bits;

      if ((!cmd_red && volt_red) || (volt_red && volt_green)) begin
         push_item.rg_cls = lfm_pkg::CLS_ERROR;
      end else begin
         push_item.rg_cls = lfm_pkg::CLS_NORMAL;
      end

      if (cmd_green) begin
         push_item.green_cls = lfm_pkg::CLS_NONE;
      end else if (volt_green) begin
         push_item.green_cls = lfm_pkg::CLS_ERROR;
      end else begin
         push_item.green_cls = lfm_pkg::CLS_NORMAL;
      end

      priority if (!cmd_red) begin
         push_item.redoff_cls = lfm_pkg::CLS_NONE;
      end else if (cur_plus_margin < {1'b0, req_red_current_base}) begin
         push_item.redoff_cls = lfm_pkg::CLS_ERROR;
      end else if (cur_plus_margin > {1'b0, req_red_current_base}) begin
         push_item.redoff_cls = lfm_pkg::CLS_NORMAL;
      end else begin
         push_item.redoff_cls = lfm_pkg::CLS_NONE;
      end
   end

endmodule

// File: rtl/lfm_queue.sv
// ----------------------------------------------------------------------------
// lfm_queue
// Two-entry queue of classified requests between front end and back end.
// ----------------------------------------------------------------------------
module lfm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lfm_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output lfm_pkg::item_type pop_item
);

   localparam int DEPTH = 2;

   lfm_pkg::item_type entry_ff [DEPTH];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != 2'(DEPTH);
   assign pop_valid  = count_ff != 2'd0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/lfm_back.sv
// ----------------------------------------------------------------------------
// lfm_back
// Back end: scan gating, per-channel streak counters and fault bits, and
// the event register, one event out per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module lfm_back #(
   parameter int CHANNELS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lfm_pkg::cfg_type              cfg,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  lfm_pkg::item_type             pop_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_event_code,
   output logic [lfm_pkg::CHANNEL_W-1:0] rsp_event_channel,
   output logic                          rsp_flash_request,
   output logic                          rsp_last_event
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NDET  = lfm_pkg::NUM_DET;

   typedef struct packed {
      logic [3:0] rg_err;
      logic [3:0] rg_nrm;
      logic [3:0] green_err;
      logic [3:0] green_nrm;
      logic [3:0] redoff_err;
      logic [3:0] redoff_nrm;
      logic [2:0] fault;
   } chan_state_type;

   typedef struct packed {
      logic [3:0] err;
      logic [3:0] nrm;
      logic       set;
      logic       clr;
   } track_type;

   function automatic track_type track(input logic [3:0] err, input logic [3:0] nrm,
                                       input lfm_pkg::cls_type cls, input logic bit_on,
                                       input logic [3:0] thr);
      track_type  res;
      logic [4:0] err_inc;
      logic [4:0] nrm_inc;
      err_inc = {1'b0, err} + 5'd1;
      nrm_inc = {1'b0, nrm} + 5'd1;
      res.err = err;
      res.nrm = nrm;
      res.set = 1'b0;
      res.clr = 1'b0;
      unique case (cls)
         lfm_pkg::CLS_ERROR: begin
            res.nrm = '0;
            if (err != lfm_pkg::COUNT_MAX) res.err = err_inc[3:0];
            res.set = (err_inc == {1'b0, thr}) && !bit_on;
         end
         lfm_pkg::CLS_NORMAL: begin
            res.err = '0;
            if (nrm != lfm_pkg::COUNT_MAX) res.nrm = nrm_inc[3:0];
            res.clr = (nrm_inc == {1'b0, thr}) && bit_on;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   chan_state_type       chan_ff [CHANNELS];
   chan_state_type       chan_cur;
   chan_state_type       chan_in;
   logic [IDX_W-1:0]     idx;
   logic [5:0]           startup_ff;
   logic [5:0]           startup_in;
   logic                 any_fault_ff;
   logic                 any_fault_in;
   logic                 scan_blocked_ff;
   logic                 scan_blocked_in;
   logic [NDET-1:0]      pend_ff;
   logic [NDET-1:0]      pend_in;
   logic [NDET-1:0]      set_ff;
   logic [NDET-1:0]      flash_ff;
   logic [lfm_pkg::CHANNEL_W-1:0] evt_chan_ff;
   logic [NDET-1:0]      low;
   logic [NDET-1:0]      rest;
   logic [NDET-1:0]      set_vec;
   logic [NDET-1:0]      clr_vec;
   logic                 is_sample;
   logic                 check;
   logic                 do_pop;
   track_type            rg_trk;
   track_type            green_trk;
   track_type            redoff_trk;
   lfm_pkg::cls_type     rg_cls;
   lfm_pkg::cls_type     green_cls;
   lfm_pkg::cls_type     redoff_cls;
   lfm_pkg::event_code_type code;

   assign idx       = pop_item.channel[IDX_W-1:0];
   assign chan_cur  = chan_ff[idx];
   assign is_sample = pop_item.kind == lfm_pkg::KIND_SAMPLE;
   assign check     = is_sample && pop_item.chan_ok && cfg.detect_enable && !scan_blocked_ff
                      && (startup_ff >= cfg.startup_scans);

   assign rg_cls     = (check && cfg.voltage_check_enable) ? pop_item.rg_cls : lfm_pkg::CLS_NONE;
   assign green_cls  = (check && cfg.voltage_check_enable) ? pop_item.green_cls
                                                           : lfm_pkg::CLS_NONE;
   assign redoff_cls = (check && cfg.current_check_enable) ? pop_item.redoff_cls
                                                           : lfm_pkg::CLS_NONE;

   assign rg_trk     = track(chan_cur.rg_err, chan_cur.rg_nrm, rg_cls,
                             chan_cur.fault[lfm_pkg::FAULT_RG], cfg.fault_threshold);
   assign green_trk  = track(chan_cur.green_err, chan_cur.green_nrm, green_cls,
                             chan_cur.fault[lfm_pkg::FAULT_GREEN], cfg.fault_threshold);
   assign redoff_trk = track(chan_cur.redoff_err, chan_cur.redoff_nrm, redoff_cls,
                             chan_cur.fault[lfm_pkg::FAULT_REDOFF], cfg.fault_threshold);

   always_comb begin
      set_vec                     = '0;
      clr_vec                     = '0;
      set_vec[lfm_pkg::DET_RG]     = rg_trk.set;
      set_vec[lfm_pkg::DET_GREEN]  = green_trk.set;
      set_vec[lfm_pkg::DET_REDOFF] = redoff_trk.set;
      clr_vec[lfm_pkg::DET_RG]     = rg_trk.clr;
      clr_vec[lfm_pkg::DET_GREEN]  = green_trk.clr;
      clr_vec[lfm_pkg::DET_REDOFF] = redoff_trk.clr;
   end

   always_comb begin
      chan_in            = chan_cur;
      chan_in.rg_err     = rg_trk.err;
      chan_in.rg_nrm     = rg_trk.nrm;
      chan_in.green_err  = green_trk.err;
      chan_in.green_nrm  = green_trk.nrm;
      chan_in.redoff_err = redoff_trk.err;
      chan_in.redoff_nrm = redoff_trk.nrm;
      if (rg_trk.set)     chan_in.fault[lfm_pkg::FAULT_RG] = 1'b1;
      if (rg_trk.clr)     chan_in.fault[lfm_pkg::FAULT_RG] = 1'b0;
      if (green_trk.set)  chan_in.fault[lfm_pkg::FAULT_GREEN] = 1'b1;
      if (green_trk.clr)  chan_in.fault[lfm_pkg::FAULT_GREEN] = 1'b0;
      if (redoff_trk.set) chan_in.fault[lfm_pkg::FAULT_REDOFF] = 1'b1;
      if (redoff_trk.clr) chan_in.fault[lfm_pkg::FAULT_REDOFF] = 1'b0;
      if (!is_sample)     chan_in.fault = pop_item.restore_bits;
   end

   // lowest pending detector goes out first
   assign low  = pend_ff & (~pend_ff + NDET'(1));
   assign rest = pend_ff & ~low;

   assign pop_ready = (rest == '0) && ((pend_ff == '0) || rsp_ready);
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      any_fault_in    = any_fault_ff;
      startup_in      = startup_ff;
      scan_blocked_in = scan_blocked_ff;
      if (do_pop) begin
         any_fault_in = any_fault_ff | (|set_vec);
         if (is_sample && pop_item.last_in_scan) begin
            if (startup_ff != lfm_pkg::STARTUP_MAX) startup_in = startup_ff + 6'd1;
            scan_blocked_in = any_fault_in;
         end
      end
   end

   always_comb begin
      priority if (do_pop) begin
         pend_in = set_vec | clr_vec;
      end else if (rsp_valid && rsp_ready) begin
         pend_in = rest;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_ff      <= '0;
         any_fault_ff    <= 1'b0;
         scan_blocked_ff <= 1'b0;
         pend_ff         <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            chan_ff[i] <= '0;
         end
      end else begin
         startup_ff      <= startup_in;
         any_fault_ff    <= any_fault_in;
         scan_blocked_ff <= scan_blocked_in;
         pend_ff         <= pend_in;
         if (do_pop && pop_item.chan_ok) begin
            chan_ff[idx] <= chan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         set_ff                        <= set_vec;
         flash_ff                      <= '0;
         flash_ff[lfm_pkg::DET_RG]     <= set_vec[lfm_pkg::DET_RG] & cfg.voltage_flash_enable;
         flash_ff[lfm_pkg::DET_GREEN]  <= set_vec[lfm_pkg::DET_GREEN] & cfg.voltage_flash_enable;
         flash_ff[lfm_pkg::DET_REDOFF] <= set_vec[lfm_pkg::DET_REDOFF] & cfg.current_flash_enable;
         evt_chan_ff                   <= pop_item.channel;
      end
   end

   always_comb begin
      unique case (low)
         3'b001:  code = (|(low & set_ff)) ? lfm_pkg::EVT_RG_SET : lfm_pkg::EVT_RG_CLEAR;
         3'b010:  code = (|(low & set_ff)) ? lfm_pkg::EVT_GREEN_SET : lfm_pkg::EVT_GREEN_CLEAR;
         3'b100:  code = (|(low & set_ff)) ? lfm_pkg::EVT_REDOFF_SET : lfm_pkg::EVT_REDOFF_CLEAR;
         default: code = lfm_pkg::EVT_RG_SET;
      endcase
   end

   assign rsp_valid         = pend_ff != '0;
   assign rsp_event_code    = code;
   assign rsp_event_channel = evt_chan_ff;
   assign rsp_flash_request = |(low & flash_ff);
   assign rsp_last_event    = rest == '0;

endmodule

// File: tb/tb_lamp_fault_monitor_unit.sv
// ----------------------------------------------------------------------------
// tb_lamp_fault_monitor_unit
// Self-checking bench for the lamp fault monitor. Channel samples and
// restores go in over the request channel, and registers are written over
// the csr channel. A behavioural model of the streak counters, fault bits
// and scan gating predicts every event. Each event seen on the response
// channel is compared with the oldest prediction. The run covers reset
// defaults, startup gating with saturation, each detector's set and clear
// events, zero threshold, random fault and healthy streaks, and blocking
// after a latched fault. Both channels see random back-pressure and gaps.
// ----------------------------------------------------------------------------
module tb_lamp_fault_monitor_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lfm_pkg::*;

   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 30;

   typedef struct {
      kind_type             kind;
      logic [CHANNEL_W-1:0] channel;
      logic                 last_in_scan;
      logic [2:0]           commanded;
      logic [1:0]           voltage;
      logic [7:0]           current;
      logic [7:0]           current_base;
      logic [7:0]           current_margin;
      logic [2:0]           restore_bits;
   } lamp_sample_t;

   typedef struct {
      event_code_type       code;
      logic [CHANNEL_W-1:0] channel;
      logic                 flash;
      logic                 last;
   } lamp_event_t;

   typedef enum logic [1:0] {
      STREAK_HOLD,
      STREAK_SET,
      STREAK_CLEAR
   } streak_result_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_kind = 1'b0;
   logic [CHANNEL_W-1:0]   req_channel = '0;
   logic                   req_last_in_scan = 1'b0;
   logic [2:0]             req_commanded = '0;
   logic [1:0]             req_voltage_readback = '0;
   logic [7:0]             req_red_current = '0;
   logic [7:0]             req_red_current_base = '0;
   logic [7:0]             req_red_current_margin = '0;
   logic [2:0]             req_restore_bits = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_event_code;
   logic [CHANNEL_W-1:0]   rsp_event_channel;
   logic                   rsp_flash_request;
   logic                   rsp_last_event;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // model of the block
   cfg_type    cfg;
   logic [3:0] err_count [NUM_DET][32];
   logic [3:0] nrm_count [NUM_DET][32];
   logic [2:0] fault_state [32];
   logic [5:0] scans_seen;
   logic       fault_latched;
   logic       checks_blocked;

   lamp_event_t pending_events [$];
   int          mismatch_count = 0;
   int          rsp_hold = 0;
   logic        rsp_stall_on = 1'b1;
   logic        req_gaps_on = 1'b1;

   lamp_fault_monitor_unit #(
      .CHANNELS(32)
   ) u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_kind               (req_kind),
      .req_channel            (req_channel),
      .req_last_in_scan       (req_last_in_scan),
      .req_commanded          (req_commanded),
      .req_voltage_readback   (req_voltage_readback),
      .req_red_current        (req_red_current),
      .req_red_current_base   (req_red_current_base),
      .req_red_current_margin (req_red_current_margin),
      .req_restore_bits       (req_restore_bits),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_event_code         (rsp_event_code),
      .rsp_event_channel      (rsp_event_channel),
      .rsp_flash_request      (rsp_flash_request),
      .rsp_last_event         (rsp_last_event),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic streak_result_t advance_streak(int det, cls_type cls, int ch, int fbit);
      logic [3:0] prior;
      advance_streak = STREAK_HOLD;
      if (cls == CLS_ERROR) begin
         prior = err_count[det][ch];
         nrm_count[det][ch] = '0;
         if (prior < COUNT_MAX) err_count[det][ch] = prior + 4'd1;
         if (prior < cfg.fault_threshold && err_count[det][ch] == cfg.fault_threshold
             && !fault_state[ch][fbit]) begin
            fault_state[ch][fbit] = 1'b1;
            fault_latched = 1'b1;
            advance_streak = STREAK_SET;
         end
      end else if (cls == CLS_NORMAL) begin
         prior = nrm_count[det][ch];
         err_count[det][ch] = '0;
         if (prior < COUNT_MAX) nrm_count[det][ch] = prior + 4'd1;
         if (prior < cfg.fault_threshold && nrm_count[det][ch] == cfg.fault_threshold
             && fault_state[ch][fbit]) begin
            fault_state[ch][fbit] = 1'b0;
            advance_streak = STREAK_CLEAR;
         end
      end
   endfunction

   task automatic predict_lamp_events(input lamp_sample_t s);
      cls_type        cls [NUM_DET];
      streak_result_t res;
      lamp_event_t    ev;
      lamp_event_t    item_events [$];
      event_code_type set_code;
      event_code_type clear_code;
      logic           set_flash;
      int             fbit;
      int             limit;
      int             ch;
      ch = s.channel;
      if (s.kind == KIND_RESTORE) begin
         fault_state[ch] = s.restore_bits;
         return;
      end
      for (int d = 0; d < NUM_DET; d++) cls[d] = CLS_NONE;
      if (cfg.detect_enable && !checks_blocked && scans_seen >= cfg.startup_scans) begin
         if (cfg.voltage_check_enable) begin
            cls[DET_RG] = ((!s.commanded[1] && s.voltage[1]) || s.voltage == 2'b11) ?
                          CLS_ERROR : CLS_NORMAL;
            if (!s.commanded[0]) cls[DET_GREEN] = s.voltage[0] ? CLS_ERROR : CLS_NORMAL;
         end
         if (cfg.current_check_enable && s.commanded[1]) begin
            limit = int'(s.current_base) - int'(s.current_margin);
            if (int'(s.current) < limit) cls[DET_REDOFF] = CLS_ERROR;
            else if (int'(s.current) > limit) cls[DET_REDOFF] = CLS_NORMAL;
         end
         for (int d = 0; d < NUM_DET; d++) begin
            case (d)
               DET_RG: begin
                  fbit = FAULT_RG;
                  set_code = EVT_RG_SET;
                  clear_code = EVT_RG_CLEAR;
                  set_flash = cfg.voltage_flash_enable;
               end
               DET_GREEN: begin
                  fbit = FAULT_GREEN;
                  set_code = EVT_GREEN_SET;
                  clear_code = EVT_GREEN_CLEAR;
                  set_flash = cfg.voltage_flash_enable;
               end
               default: begin
                  fbit = FAULT_REDOFF;
                  set_code = EVT_REDOFF_SET;
                  clear_code = EVT_REDOFF_CLEAR;
                  set_flash = cfg.current_flash_enable;
               end
            endcase
            res = advance_streak(d, cls[d], ch, fbit);
            if (res != STREAK_HOLD) begin
               ev.code = (res == STREAK_SET) ? set_code : clear_code;
               ev.channel = s.channel;
               ev.flash = (res == STREAK_SET) ? set_flash : 1'b0;
               ev.last = 1'b0;
               item_events.push_back(ev);
            end
         end
      end
      if (s.last_in_scan) begin
         if (scans_seen < STARTUP_MAX) scans_seen = scans_seen + 6'd1;
         checks_blocked = fault_latched;
      end
      if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
      foreach (item_events[i]) pending_events.push_back(item_events[i]);
   endtask

   function automatic lamp_sample_t make_sample(int ch, logic last, logic [2:0] cmd,
                                                logic [1:0] volt, logic [7:0] cur,
                                                logic [7:0] base, logic [7:0] margin);
      lamp_sample_t s;
      s.kind = KIND_SAMPLE;
      s.channel = ch[CHANNEL_W-1:0];
      s.last_in_scan = last;
      s.commanded = cmd;
      s.voltage = volt;
      s.current = cur;
      s.current_base = base;
      s.current_margin = margin;
      s.restore_bits = $urandom;
      return s;
   endfunction

   function automatic lamp_sample_t make_restore(int ch, logic [2:0] bits, logic last);
      lamp_sample_t s;
      s = make_sample(ch, last, $urandom, $urandom, $urandom, $urandom, $urandom);
      s.kind = KIND_RESTORE;
      s.restore_bits = bits;
      return s;
   endfunction

   function automatic lamp_sample_t random_sample();
      lamp_sample_t s;
      s = make_sample($urandom_range(0, 31), $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
      s.kind = kind_type'($urandom_range(0, 1));
      return s;
   endfunction

   // red-green error; green and red-off errors when red is commanded
   function automatic lamp_sample_t fault_sample(int ch);
      logic [2:0] cmd;
      logic [7:0] base;
      logic [7:0] margin;
      int         lim;
      cmd = {1'($urandom), 1'($urandom), 1'b0};
      base = $urandom_range(255, 1);
      margin = $urandom_range(int'(base) - 1, 0);
      lim = int'(base) - int'(margin);
      return make_sample(ch, 1'b0, cmd, cmd[1] ? 2'b11 : {1'b1, 1'($urandom)},
                         $urandom_range(lim - 1, 0), base, margin);
   endfunction

   function automatic lamp_sample_t healthy_sample(int ch);
      logic [2:0] cmd;
      logic [7:0] base;
      logic [7:0] margin;
      int         lim;
      cmd = $urandom;
      base = $urandom;
      margin = $urandom;
      if (int'(base) - int'(margin) >= 255) margin = 8'd1;
      lim = int'(base) - int'(margin);
      return make_sample(ch, 1'b0, cmd, {cmd[1], cmd[0] & ~cmd[1]},
                         (lim < 0) ? 8'($urandom) : 8'($urandom_range(255, lim + 1)),
                         base, margin);
   endfunction

   task automatic send_sample(input lamp_sample_t s);
      req_valid <= 1'b1;
      req_kind <= s.kind;
      req_channel <= s.channel;
      req_last_in_scan <= s.last_in_scan;
      req_commanded <= s.commanded;
      req_voltage_readback <= s.voltage;
      req_red_current <= s.current;
      req_red_current_base <= s.current_base;
      req_red_current_margin <= s.current_margin;
      req_restore_bits <= s.restore_bits;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_lamp_events(s);
      if (req_gaps_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (idle_length()) @(posedge clock);
      end
   endtask

   task automatic await_drain();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_DETECT_ENABLE:        cfg.detect_enable = value[0];
         CSR_VOLTAGE_CHECK_ENABLE: cfg.voltage_check_enable = value[0];
         CSR_CURRENT_CHECK_ENABLE: cfg.current_check_enable = value[0];
         CSR_VOLTAGE_FLASH_ENABLE: cfg.voltage_flash_enable = value[0];
         CSR_CURRENT_FLASH_ENABLE: cfg.current_flash_enable = value[0];
         CSR_FAULT_THRESHOLD:      cfg.fault_threshold = value[3:0];
         CSR_STARTUP_SCANS:        cfg.startup_scans = value[5:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic det, input logic vchk, input logic cchk,
                               input logic vfl, input logic cfl, input logic [3:0] thr,
                               input logic [5:0] startup);
      write_register(CSR_DETECT_ENABLE, CSR_DATA_W'(det));
      write_register(CSR_VOLTAGE_CHECK_ENABLE, CSR_DATA_W'(vchk));
      write_register(CSR_CURRENT_CHECK_ENABLE, CSR_DATA_W'(cchk));
      write_register(CSR_VOLTAGE_FLASH_ENABLE, CSR_DATA_W'(vfl));
      write_register(CSR_CURRENT_FLASH_ENABLE, CSR_DATA_W'(cfl));
      write_register(CSR_FAULT_THRESHOLD, CSR_DATA_W'(thr));
      write_register(CSR_STARTUP_SCANS, startup);
   endtask

   task automatic test_reset_defaults();
      repeat (6) send_sample(random_sample());
      send_sample(fault_sample(0));
   endtask

   task automatic test_startup_scans();
      lamp_sample_t s;
      await_drain();
      apply_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 4'd1, STARTUP_MAX);
      while (scans_seen < STARTUP_MAX) begin
         s = fault_sample($urandom_range(0, 31));
         s.last_in_scan = 1'b1;
         send_sample(s);
      end
      // push the count past its ceiling without latching anything
      for (int i = 0; i < 2; i++) begin
         s = healthy_sample(i);
         s.last_in_scan = 1'b1;
         send_sample(s);
      end
   endtask

   task automatic test_detector_events();
      req_gaps_on = 1'b0;
      rsp_stall_on = 1'b0;
      send_sample(make_sample(2, 1'b0, 3'b000, 2'b10, 8'd0, 8'd0, 8'd0));
      send_sample(make_sample(2, 1'b0, 3'b011, 2'b11, 8'd0, 8'd255, 8'd0));
      send_sample(make_sample(2, 1'b0, 3'b100, 2'b01, 8'd128, 8'd128, 8'd0));
      send_sample(make_sample(2, 1'b0, 3'b110, 2'b10, 8'd255, 8'd0, 8'd255));
      send_sample(make_sample(31, 1'b0, 3'b010, 2'b11, 8'd0, 8'd200, 8'd100));
      // current equal to the limit leaves the red-off streak alone
      send_sample(make_sample(31, 1'b0, 3'b010, 2'b10, 8'd100, 8'd150, 8'd50));
      send_sample(make_restore(4, 3'b111, 1'b1));
      send_sample(make_sample(4, 1'b0, 3'b010, 2'b11, 8'd0, 8'd255, 8'd0));
      send_sample(make_sample(4, 1'b0, 3'b010, 2'b10, 8'd255, 8'd0, 8'd0));
      send_sample(make_restore(31, 3'b000, 1'b0));
      send_sample(make_sample(31, 1'b0, 3'b001, 2'b01, 8'd7, 8'd7, 8'd7));
      req_gaps_on = 1'b1;
      rsp_stall_on = 1'b1;
      await_drain();
      write_register(CSR_VOLTAGE_FLASH_ENABLE, CSR_DATA_W'(0));
      write_register(CSR_CURRENT_FLASH_ENABLE, CSR_DATA_W'(1));
      send_sample(make_sample(6, 1'b0, 3'b010, 2'b11, 8'd10, 8'd100, 8'd20));
      send_sample(make_sample(6, 1'b0, 3'b010, 2'b10, 8'd255, 8'd100, 8'd20));
   endtask

   task automatic test_zero_threshold();
      await_drain();
      write_register(CSR_FAULT_THRESHOLD, CSR_DATA_W'(0));
      send_sample(fault_sample(7));
      send_sample(fault_sample(7));
      send_sample(healthy_sample(7));
      send_sample(healthy_sample(7));
   endtask

   task automatic test_random_streaks();
      lamp_sample_t s;
      logic [3:0]   thr;
      logic         healthy;
      logic         paused;
      int           sent;
      int           run;
      int           pick;
      int           ch;
      paused = 1'b0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         await_drain();
         case ($urandom_range(0, 7))
            0: thr = 4'd1;
            1: thr = COUNT_MAX;
            2: thr = 4'd0;
            default: thr = $urandom_range(1, 4);
         endcase
         apply_config($urandom_range(0, 7) != 0, $urandom_range(0, 3) != 0,
                      $urandom_range(0, 3) != 0, $urandom, $urandom, thr,
                      $urandom_range(0, 63));
         req_gaps_on = $urandom_range(0, 3) != 0;
         rsp_stall_on = $urandom_range(0, 3) != 0;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               run = $urandom_range(1, int'(cfg.fault_threshold) + 2);
               healthy = pick >= 4;
               for (int k = 0; k < run; k++) begin
                  if ($urandom_range(0, 7) == 0) begin
                     s = random_sample();
                     s.channel = ch;
                  end else begin
                     s = healthy ? healthy_sample(ch) : fault_sample(ch);
                  end
                  if (s.kind == KIND_SAMPLE) s.last_in_scan = 1'b0;
                  send_sample(s);
                  sent++;
               end
            end else if (pick == 7) begin
               send_sample(make_restore(ch, $urandom, $urandom));
               sent++;
            end else begin
               s = random_sample();
               if (s.kind == KIND_SAMPLE) s.last_in_scan = 1'b0;
               send_sample(s);
               sent++;
            end
            // hold off until every pending event is out
            if (!paused && phase == 2 && sent >= PHASE_ITEMS / 2) begin
               paused = 1'b1;
               await_drain();
            end
         end
      end
   endtask

   task automatic test_scan_blocking();
      lamp_sample_t s;
      await_drain();
      req_gaps_on = 1'b1;
      rsp_stall_on = 1'b1;
      apply_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 4'd1, 6'd0);
      send_sample(make_restore(8, 3'b000, 1'b0));
      send_sample(make_restore(9, 3'b000, 1'b0));
      send_sample(make_restore(10, 3'b000, 1'b0));
      send_sample(fault_sample(8));
      // latch mid-scan, then close the scan on a checked sample
      s = fault_sample(9);
      s.last_in_scan = 1'b1;
      send_sample(s);
      send_sample(fault_sample(10));
      send_sample(healthy_sample(8));
      repeat (12) send_sample(random_sample());
      await_drain();
      write_register(CSR_DETECT_ENABLE, CSR_DATA_W'(0));
      repeat (6) send_sample(random_sample());
   endtask

   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
         rsp_hold <= idle_length() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_events
      lamp_event_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t unexpected event: code %0d channel %0d flash %0b last %0b",
                        $realtime, rsp_event_code, rsp_event_channel, rsp_flash_request,
                        rsp_last_event);
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_code !== want.code || rsp_event_channel !== want.channel ||
                rsp_flash_request !== want.flash || rsp_last_event !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t event mismatch: expected code %0d ch %0d flash %0b last %0b, %s %0d ch %0d flash %0b last %0b",
                           $realtime, want.code, want.channel, want.flash, want.last,
                           "got code", rsp_event_code, rsp_event_channel,
                           rsp_flash_request, rsp_last_event);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      cfg = '0;
      cfg.fault_threshold = RESET_THRESHOLD;
      cfg.startup_scans = RESET_STARTUP;
      for (int d = 0; d < NUM_DET; d++) begin
         for (int c = 0; c < 32; c++) begin
            err_count[d][c] = '0;
            nrm_count[d][c] = '0;
         end
      end
      for (int c = 0; c < 32; c++) fault_state[c] = '0;
      scans_seen = '0;
      fault_latched = 1'b0;
      checks_blocked = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_startup_scans();
      test_detector_events();
      test_zero_threshold();
      test_random_streaks();
      test_scan_blocking();
      await_drain();
      if (mismatch_count == 0 && pending_events.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
